### rtl/core/rtab_pkg.sv
// Types, widths and constants shared by the tone adjust and blend pipeline.
package rtab_pkg;

   localparam int FRACTION_BITS = 16;
   localparam int MODE_W        = 2;
   localparam int COLOUR_W      = 32;
   localparam int AMOUNT_W      = 24;
   localparam int CHAN_W        = 8;
   localparam int NUM_CHAN      = 3;

   // amount decode
   localparam int POS_W    = AMOUNT_W - 1;
   localparam int CLAMP_W  = FRACTION_BITS + 1;
   localparam int FACTOR_W = ((POS_W > CLAMP_W) ? POS_W : CLAMP_W) + 1;
   localparam int WEIGHT_W = CLAMP_W + CHAN_W;
   localparam int DIFF_W   = CHAN_W + 1;

   // darken divider: one quotient bit per stage
   localparam int DIV_STEPS = CHAN_W;
   localparam int DVS_W     = FACTOR_W + DIV_STEPS;
   localparam int REM_W     = (((CHAN_W + FRACTION_BITS + 1) > FACTOR_W) ?
                               (CHAN_W + FRACTION_BITS + 1) : FACTOR_W) + 1;

   // pipeline shape
   localparam int FRONT_STAGES = 2;
   localparam int BLEND_STAGES = 3;
   localparam int NUM_STAGES   = FRONT_STAGES + DIV_STEPS;

   // blend: exact sum divided by 255 * ONE, done as a shift then a divide by 255
   localparam int PROD_W      = DIFF_W + WEIGHT_W + 1;
   localparam int T_W         = 2 * CHAN_W + 2;
   localparam int U_W         = 2 * CHAN_W + 1;
   localparam int RECIP_W     = CHAN_W + 1;
   localparam int RECIP_SHIFT = 2 * CHAN_W;
   localparam int QE_W        = U_W + RECIP_W - RECIP_SHIFT;
   localparam int RMD_W       = U_W + 1;

   typedef logic [CHAN_W-1:0] chan_type;

   localparam chan_type                 CHAN_MAX  = '1;
   localparam logic [FACTOR_W-1:0]      ONE_F     = FACTOR_W'(1) << FRACTION_BITS;
   localparam logic [FACTOR_W-1:0]      HALF_F    = ONE_F >> 1;
   localparam logic [WEIGHT_W-1:0]      HALF_DEN  = WEIGHT_W'(CHAN_MAX) << (FRACTION_BITS - 1);
   localparam logic [T_W-1:0]           BLEND_BIAS = T_W'(CHAN_MAX) << CHAN_W;
   localparam logic [RECIP_W-1:0]       RECIP_255 = RECIP_W'((1 << CHAN_W) + 1);

   typedef enum logic [MODE_W-1:0] {
      MODE_ALPHA_SCALE = 2'd0,
      MODE_DARKEN      = 2'd1,
      MODE_LIGHTEN     = 2'd2,
      MODE_BLEND       = 2'd3
   } mode_type;

   typedef struct packed {
      mode_type                mode;
      logic [COLOUR_W-1:0]     base;
      logic [COLOUR_W-1:0]     over;
      logic [CLAMP_W-1:0]      clamped;
      logic [FACTOR_W-1:0]     factor;
   } prep_type;

   typedef struct packed {
      mode_type                            mode;
      chan_type                            alpha;
      chan_type [NUM_CHAN-1:0]             rgb;
      logic [NUM_CHAN-1:0][REM_W-1:0]      rem;
      chan_type [NUM_CHAN-1:0]             quo;
      logic [DVS_W-1:0]                    dvs;
   } div_type;

   typedef struct packed {
      logic [WEIGHT_W-1:0]                 weight;
      logic [NUM_CHAN-1:0][DIFF_W-1:0]     diff;
      chan_type [NUM_CHAN-1:0]             from;
   } blend_type;

endpackage

### rtl/core/rtab_req_if.sv
// Request channel: mode, colors and amount with valid/ready.
interface rtab_req_if;
   import rtab_pkg::*;

   logic                        valid;
   logic                        ready;
   logic [MODE_W-1:0]           mode;
   logic [COLOUR_W-1:0]         base_colour;
   logic [COLOUR_W-1:0]         over_colour;
   logic signed [AMOUNT_W-1:0]  amount;

   modport source (output valid, output mode, output base_colour, output over_colour,
                   output amount, input ready);
   modport sink   (input valid, input mode, input base_colour, input over_colour,
                   input amount, output ready);
endinterface

### rtl/core/rtab_rsp_if.sv
// Response channel: adjusted color with valid/ready.
interface rtab_rsp_if;
   import rtab_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [COLOUR_W-1:0]  result_colour;

   modport source (output valid, output result_colour, input ready);
   modport sink   (input valid, input result_colour, output ready);
endinterface

### rtl/core/rtab_front.sv
// Front stages: amount decode, then alpha scale, lighten, blend weight and divider setup.
module rtab_front (
   input  logic                                   clock,
   input  logic [1:0]                             stage_en,
   input  rtab_pkg::mode_type                     in_mode,
   input  logic [rtab_pkg::COLOUR_W-1:0]          in_base,
   input  logic [rtab_pkg::COLOUR_W-1:0]          in_over,
   input  logic signed [rtab_pkg::AMOUNT_W-1:0]   in_amount,
   output rtab_pkg::div_type                      div_out,
   output rtab_pkg::blend_type                    blend_out
);
   import rtab_pkg::*;

   localparam int AP_W = CHAN_W + CLAMP_W;
   localparam int LP_W = CHAN_W + FACTOR_W;

   prep_type   prep_ff, prep_in;
   div_type    div_ff, div_in;
   blend_type  blend_ff, blend_in;

   logic [POS_W-1:0]                   pos;
   logic [FACTOR_W-1:0]                pos_ext;
   chan_type                           base_a, over_a, new_a;
   chan_type [NUM_CHAN-1:0]            base_rgb, over_rgb, light;
   logic [AP_W-1:0]                    alpha_prod;
   logic [AP_W:0]                      alpha_sum;
   logic [NUM_CHAN-1:0][LP_W-1:0]      light_prod;
   logic [NUM_CHAN-1:0][LP_W:0]        light_sum;

   // stage 1: positive part and clamp of the amount
   always_comb begin
      pos             = in_amount[AMOUNT_W-1] ? '0 : in_amount[POS_W-1:0];
      pos_ext         = FACTOR_W'(pos);
      prep_in.mode    = in_mode;
      prep_in.base    = in_base;
      prep_in.over    = in_over;
      prep_in.clamped = (pos_ext > ONE_F) ? ONE_F[CLAMP_W-1:0] : pos_ext[CLAMP_W-1:0];
      prep_in.factor  = ONE_F + pos_ext;
   end

   // stage 2: the single-multiply modes finish here
   always_comb begin
      base_a   = prep_ff.base[COLOUR_W-1 -: CHAN_W];
      over_a   = prep_ff.over[COLOUR_W-1 -: CHAN_W];
      base_rgb = prep_ff.base[NUM_CHAN*CHAN_W-1:0];
      over_rgb = prep_ff.over[NUM_CHAN*CHAN_W-1:0];

      alpha_prod = AP_W'(base_a) * AP_W'(prep_ff.clamped);
      alpha_sum  = (AP_W+1)'(alpha_prod) + (AP_W+1)'(HALF_F);
      new_a      = alpha_sum[FRACTION_BITS +: CHAN_W];

      for (int c = 0; c < NUM_CHAN; c++) begin
         light_prod[c] = LP_W'(base_rgb[c]) * LP_W'(prep_ff.factor);
         light_sum[c]  = (LP_W+1)'(light_prod[c]) + (LP_W+1)'(HALF_F);
         if (|light_sum[c][LP_W:FRACTION_BITS+CHAN_W]) begin
            light[c] = CHAN_MAX;
         end else begin
            light[c] = light_sum[c][FRACTION_BITS +: CHAN_W];
         end
      end

      div_in.mode  = prep_ff.mode;
      div_in.alpha = (prep_ff.mode == MODE_ALPHA_SCALE) ? new_a : base_a;
      div_in.rgb   = (prep_ff.mode == MODE_LIGHTEN) ? light : base_rgb;
      div_in.quo   = '0;
      // numerator 2*ch*ONE + d, divisor 2*d pre-shifted for the top quotient bit
      for (int c = 0; c < NUM_CHAN; c++) begin
         div_in.rem[c] = (REM_W'(base_rgb[c]) << (FRACTION_BITS + 1)) +
                         REM_W'(prep_ff.factor);
      end
      div_in.dvs = DVS_W'(prep_ff.factor) << DIV_STEPS;

      blend_in.weight = WEIGHT_W'(prep_ff.clamped) * WEIGHT_W'(over_a);
      for (int c = 0; c < NUM_CHAN; c++) begin
         blend_in.diff[c] = {1'b0, over_rgb[c]} - {1'b0, base_rgb[c]};
      end
      blend_in.from = base_rgb;
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         prep_ff <= prep_in;
      end
      if (stage_en[1]) begin
         div_ff   <= div_in;
         blend_ff <= blend_in;
      end
   end

   assign div_out   = div_ff;
   assign blend_out = blend_ff;

endmodule

### rtl/core/rtab_div_step.sv
// One restoring division step for the three color lanes, registered.
module rtab_div_step (
   input  logic               clock,
   input  logic               load,
   input  rtab_pkg::div_type  src_item,
   output rtab_pkg::div_type  dst_item
);
   import rtab_pkg::*;

   div_type                item_ff, item_in;
   logic [NUM_CHAN-1:0]    take;

   always_comb begin
      item_in = src_item;
      for (int c = 0; c < NUM_CHAN; c++) begin
         take[c] = DVS_W'(src_item.rem[c]) >= src_item.dvs;
         if (take[c]) begin
            item_in.rem[c] = src_item.rem[c] - src_item.dvs[REM_W-1:0];
         end
         item_in.quo[c] = {src_item.quo[c][CHAN_W-2:0], take[c]};
      end
      item_in.dvs = src_item.dvs >> 1;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= item_in;
      end
   end

   assign dst_item = item_ff;

endmodule

### rtl/core/rtab_blend.sv
// Blend lanes: weighted difference, divide by 255 via reciprocal, round and clamp.
module rtab_blend (
   input  logic                                   clock,
   input  logic [rtab_pkg::BLEND_STAGES-1:0]      load,
   input  rtab_pkg::blend_type                    src,
   output rtab_pkg::chan_type [rtab_pkg::NUM_CHAN-1:0] rgb_out
);
   import rtab_pkg::*;

   localparam int QP_W = U_W + RECIP_W;
   localparam logic [QE_W-1:0] SUM_LOW  = QE_W'(1 << CHAN_W);
   localparam logic [QE_W-1:0] SUM_HIGH = QE_W'(2 << CHAN_W);

   logic signed [NUM_CHAN-1:0][PROD_W-1:0] prod;
   logic [NUM_CHAN-1:0][PROD_W-1:0]        psum;
   logic [NUM_CHAN-1:0][T_W-1:0]           t, tb;
   logic [NUM_CHAN-1:0][U_W-1:0]           u1_ff, u1_in, u2_ff;
   chan_type [NUM_CHAN-1:0]                from1_ff, from2_ff;
   logic [NUM_CHAN-1:0][QP_W-1:0]          qprod;
   logic [NUM_CHAN-1:0][QE_W-1:0]          qe_ff, qe_in, q, qsum;
   logic [NUM_CHAN-1:0][RMD_W-1:0]         rmd;
   chan_type [NUM_CHAN-1:0]                rgb_ff, rgb_in;

   // (to - from) * w + den/2, floor by ONE, biased positive
   always_comb begin
      for (int c = 0; c < NUM_CHAN; c++) begin
         prod[c]  = PROD_W'($signed(src.diff[c])) *
                    PROD_W'($signed({1'b0, src.weight}));
         psum[c]  = prod[c] + PROD_W'(HALF_DEN);
         t[c]     = psum[c][FRACTION_BITS +: T_W];
         tb[c]    = t[c] + BLEND_BIAS;
         u1_in[c] = tb[c][U_W-1:0];
      end
   end

   // quotient estimate, never more than one short
   always_comb begin
      for (int c = 0; c < NUM_CHAN; c++) begin
         qprod[c] = QP_W'(u1_ff[c]) * QP_W'(RECIP_255);
         qe_in[c] = qprod[c][RECIP_SHIFT +: QE_W];
      end
   end

   always_comb begin
      for (int c = 0; c < NUM_CHAN; c++) begin
         rmd[c]  = RMD_W'(u2_ff[c]) -
                   ((RMD_W'(qe_ff[c]) << CHAN_W) - RMD_W'(qe_ff[c]));
         q[c]    = qe_ff[c] + QE_W'(rmd[c] >= RMD_W'(CHAN_MAX));
         // sum carries the bias of 256 back out
         qsum[c] = QE_W'(from2_ff[c]) + q[c];
         if (qsum[c] < SUM_LOW) begin
            rgb_in[c] = '0;
         end else if (qsum[c] >= SUM_HIGH) begin
            rgb_in[c] = CHAN_MAX;
         end else begin
            rgb_in[c] = qsum[c][CHAN_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load[0]) begin
         u1_ff    <= u1_in;
         from1_ff <= src.from;
      end
      if (load[1]) begin
         u2_ff    <= u1_ff;
         qe_ff    <= qe_in;
         from2_ff <= from1_ff;
      end
      if (load[2]) begin
         rgb_ff <= rgb_in;
      end
   end

   assign rgb_out = rgb_ff;

endmodule

### rtl/core/rgba_tone_adjust_and_blend.sv
// Top level: ten-stage pipeline for ARGB alpha scale, darken, lighten and blend.
// Throughput: one word per cycle while the output is not stalled;
// the darken divider resolves one quotient bit per stage.
// Each stage has its own valid bit, so bubbles close up while the output is stalled.
// Reset (synchronous, active high) clears the stage valid bits only; data is not reset.
module rgba_tone_adjust_and_blend (
   input  logic         clock,
   input  logic         reset,
   rtab_req_if.sink     req_ch,
   rtab_rsp_if.source   rsp_ch
);
   import rtab_pkg::*;

   logic [NUM_STAGES:1]     vld_ff, vld_in;
   logic [NUM_STAGES+1:1]   load;

   div_type                 chain    [DIV_STEPS+1];
   div_type                 step_src [DIV_STEPS];
   blend_type               blend_src;
   chan_type [NUM_CHAN-1:0] blend_rgb;
   div_type                 last;

   // a stage takes a new word when it is empty or its contents move on
   always_comb begin
      load[NUM_STAGES+1] = rsp_ch.ready;
      for (int k = NUM_STAGES; k >= 1; k--) begin
         load[k] = !vld_ff[k] || load[k+1];
      end
      vld_in[1] = load[1] ? req_ch.valid : vld_ff[1];
      for (int k = 2; k <= NUM_STAGES; k++) begin
         vld_in[k] = load[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_ch.ready = load[1];

   rtab_front u_front (
      .clock     (clock),
      .stage_en  (load[FRONT_STAGES:1]),
      .in_mode   (mode_type'(req_ch.mode)),
      .in_base   (req_ch.base_colour),
      .in_over   (req_ch.over_colour),
      .in_amount (req_ch.amount),
      .div_out   (chain[0]),
      .blend_out (blend_src)
   );

   rtab_blend u_blend (
      .clock   (clock),
      .load    (load[FRONT_STAGES+1 +: BLEND_STAGES]),
      .src     (blend_src),
      .rgb_out (blend_rgb)
   );

   // blend result joins the word once the blend lanes finish
   always_comb begin
      for (int j = 0; j < DIV_STEPS; j++) begin
         step_src[j] = chain[j];
      end
      if (chain[BLEND_STAGES].mode == MODE_BLEND) begin
         step_src[BLEND_STAGES].rgb = blend_rgb;
      end
   end

   for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
      rtab_div_step u_step (
         .clock    (clock),
         .load     (load[FRONT_STAGES+1+j]),
         .src_item (step_src[j]),
         .dst_item (chain[j+1])
      );
   end

   assign last                 = chain[DIV_STEPS];
   assign rsp_ch.valid         = vld_ff[NUM_STAGES];
   assign rsp_ch.result_colour = {last.alpha,
                                  (last.mode == MODE_DARKEN) ? last.quo : last.rgb};

   a_accept_fills_first: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> vld_ff[1])
      else $error("accepted word did not reach the first stage");

   a_block_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> (&vld_ff))
      else $error("input held off with an empty stage in the pipeline");

   a_no_repeat: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.ready && !vld_ff[NUM_STAGES-1] |=> !rsp_ch.valid)
      else $error("response word repeated after it was taken");

   a_div_remainder: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |->
         ((DVS_W+1)'(last.rem[0]) < ((DVS_W+1)'(last.dvs) << 1)) &&
         ((DVS_W+1)'(last.rem[1]) < ((DVS_W+1)'(last.dvs) << 1)) &&
         ((DVS_W+1)'(last.rem[2]) < ((DVS_W+1)'(last.dvs) << 1)))
      else $error("divider remainder not below divisor");

endmodule

### bench/tb_rgba_tone_adjust_and_blend.sv
// Self-checking bench for the ARGB tone adjust and blend pipeline: directed and random words.
`timescale 1ns / 1ps

module tb_rgba_tone_adjust_and_blend;
   import rtab_pkg::*;

   localparam int HOLD_CYCLES  = 150;
   localparam int PHASE_WORDS  = 275;
   localparam int NUM_PHASES   = 6;
   localparam int TAIL_CYCLES  = 20;

   typedef struct {
      mode_type                    mode;
      logic [COLOUR_W-1:0]         base;
      logic [COLOUR_W-1:0]         over;
      logic signed [AMOUNT_W-1:0]  amount;
   } tone_word_type;

   logic clock;
   logic reset;

   rtab_req_if req_ch ();
   rtab_rsp_if rsp_ch ();

   rgba_tone_adjust_and_blend dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   tone_word_type       pending_words[$];
   logic [COLOUR_W-1:0] expected_colours[$];
   int                  mismatches = 0;
   logic                req_taken = 1'b0;
   int                  send_gap = 0;
   int                  stall_left = 0;
   int                  hold_left = 0;
   logic                hold_request = 1'b0;
   logic                sender_quiet = 1'b0;
   logic                receiver_quiet = 1'b0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // exact fixed-point result of one word, rounded half up
   function automatic logic [COLOUR_W-1:0] adjusted_colour(tone_word_type w);
      longint unsigned one, pos, lim, d, den, wt, ch, to, n, v, a;
      logic [COLOUR_W-1:0] res;
      int i;
      one = 64'd1 << FRACTION_BITS;
      pos = w.amount[AMOUNT_W-1] ? 64'd0 : 64'(w.amount[AMOUNT_W-2:0]);
      lim = (pos > one) ? one : pos;
      a   = 64'(w.base[31:24]);
      res = w.base;
      d   = one + pos;
      den = 64'd255 * one;
      wt  = lim * 64'(w.over[31:24]);
      case (w.mode)
         MODE_ALPHA_SCALE: begin
            res[31:24] = CHAN_W'((a * lim + one / 2) >> FRACTION_BITS);
         end
         MODE_DARKEN: begin
            for (i = 0; i < NUM_CHAN; i++) begin
               ch = 64'(w.base[CHAN_W*i +: CHAN_W]);
               res[CHAN_W*i +: CHAN_W] = CHAN_W'((64'd2 * ch * one + d) / (64'd2 * d));
            end
         end
         MODE_LIGHTEN: begin
            for (i = 0; i < NUM_CHAN; i++) begin
               ch = 64'(w.base[CHAN_W*i +: CHAN_W]);
               v  = (ch * d + one / 2) >> FRACTION_BITS;
               res[CHAN_W*i +: CHAN_W] = (v > 64'd255) ? CHAN_MAX : CHAN_W'(v);
            end
         end
         default: begin
            for (i = 0; i < NUM_CHAN; i++) begin
               ch = 64'(w.base[CHAN_W*i +: CHAN_W]);
               to = 64'(w.over[CHAN_W*i +: CHAN_W]);
               n  = ch * (den - wt) + to * wt;
               v  = (64'd2 * n + den) / (64'd2 * den);
               res[CHAN_W*i +: CHAN_W] = (v > 64'd255) ? CHAN_MAX : CHAN_W'(v);
            end
         end
      endcase
      return res;
   endfunction

   // mostly no gap, some short, a few long
   function automatic int idle_length(logic quiet);
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 70)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [CHAN_W-1:0] random_channel();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0)
         return '0;
      if (r == 1)
         return CHAN_MAX;
      return CHAN_W'($urandom);
   endfunction

   function automatic tone_word_type random_word();
      tone_word_type w;
      logic [AMOUNT_W-1:0] edges[8];
      int i;
      edges = '{24'h000000, 24'h000001, 24'h00FFFF, 24'h010000,
                24'h010001, 24'h7FFFFF, 24'h800000, 24'hFFFFFF};
      w.mode = mode_type'($urandom_range(0, 3));
      for (i = 0; i < 4; i++) begin
         w.base[CHAN_W*i +: CHAN_W] = random_channel();
         w.over[CHAN_W*i +: CHAN_W] = random_channel();
      end
      case ($urandom_range(0, 9))
         0, 1, 2, 3: w.amount = AMOUNT_W'($urandom_range(0, 32'h10000));
         4, 5:       w.amount = AMOUNT_W'($urandom_range(32'h10001, 32'h7FFFF));
         6:          w.amount = edges[$urandom_range(0, 7)];
         7:          w.amount = AMOUNT_W'(-int'($urandom_range(1, 32'h800000)));
         default:    w.amount = AMOUNT_W'($urandom);
      endcase
      return w;
   endfunction

   task automatic add_word(mode_type m, logic [31:0] b, logic [31:0] o, logic [23:0] amt);
      tone_word_type w;
      w.mode   = m;
      w.base   = b;
      w.over   = o;
      w.amount = amt;
      pending_words.push_back(w);
   endtask

   task automatic drain();
      while (pending_words.size() != 0 || req_ch.valid || expected_colours.size() != 0)
         @(posedge clock);
   endtask

   // sender: next word goes out at the falling edge after the previous one was taken, unless a random gap holds it
   always @(negedge clock) begin : sender
      tone_word_type w;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_taken) begin
         if (send_gap > 0) begin
            send_gap     <= send_gap - 1;
            req_ch.valid <= 1'b0;
         end else if (pending_words.size() != 0) begin
            w = pending_words.pop_front();
            req_ch.mode        <= w.mode;
            req_ch.base_colour <= w.base;
            req_ch.over_colour <= w.over;
            req_ch.amount      <= w.amount;
            req_ch.valid       <= 1'b1;
            send_gap           <= idle_length(sender_quiet);
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin : receiver
      int n;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left    <= hold_left - 1;
         rsp_ch.ready <= 1'b0;
      end else if (hold_request) begin
         hold_request <= 1'b0;
         hold_left    <= HOLD_CYCLES - 1;
         rsp_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left   <= stall_left - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         n = idle_length(receiver_quiet);
         if (n == 0) begin
            rsp_ch.ready <= 1'b1;
         end else begin
            rsp_ch.ready <= 1'b0;
            stall_left   <= n - 1;
         end
      end
   end

   always @(posedge clock) begin : monitor
      tone_word_type       w;
      logic [COLOUR_W-1:0] want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_ch.valid && req_ch.ready;
         // check before queueing so a stray word never meets its own expectation
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_colours.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result word %h", rsp_ch.result_colour);
            end else begin
               want = expected_colours.pop_front();
               if (rsp_ch.result_colour !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("result_colour mismatch: expected %h actual %h",
                              want, rsp_ch.result_colour);
               end
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            w.mode   = mode_type'(req_ch.mode);
            w.base   = req_ch.base_colour;
            w.over   = req_ch.over_colour;
            w.amount = req_ch.amount;
            expected_colours.push_back(adjusted_colour(w));
         end
      end
   end

   initial begin
      #3_000_000;
      $display("simulation failed");
      $finish;
   end

   initial begin
      int p, k;
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.mode        = MODE_ALPHA_SCALE;
      req_ch.base_colour = '0;
      req_ch.over_colour = '0;
      req_ch.amount      = '0;
      rsp_ch.ready       = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // alpha scale: zero, one, clamp above one, negatives, half-up rounding
      add_word(MODE_ALPHA_SCALE, 32'hFFFFFFFF, 32'h00000000, 24'h000000);
      add_word(MODE_ALPHA_SCALE, 32'hFF123456, 32'hFFFFFFFF, 24'h010000);
      add_word(MODE_ALPHA_SCALE, 32'hFFFFFFFF, 32'h00000000, 24'h7FFFFF);
      add_word(MODE_ALPHA_SCALE, 32'hFFFFFFFF, 32'h00000000, 24'h800000);
      add_word(MODE_ALPHA_SCALE, 32'hFF00FF00, 32'h00000000, 24'hFFFFFF);
      add_word(MODE_ALPHA_SCALE, 32'h01ABCDEF, 32'h00000000, 24'h008000);
      add_word(MODE_ALPHA_SCALE, 32'h00000000, 32'hFFFFFFFF, 24'h00C000);
      // darken
      add_word(MODE_DARKEN, 32'hFFFFFFFF, 32'h00000000, 24'h000000);
      add_word(MODE_DARKEN, 32'h80010203, 32'hFFFFFFFF, 24'h010000);
      add_word(MODE_DARKEN, 32'hFFFFFFFF, 32'h00000000, 24'h7FFFFF);
      add_word(MODE_DARKEN, 32'h7FFF80FF, 32'h00000000, 24'h800000);
      add_word(MODE_DARKEN, 32'h00000000, 32'h00000000, 24'h018000);
      // lighten: saturation and negative amounts
      add_word(MODE_LIGHTEN, 32'hFF7F8081, 32'h00000000, 24'h010000);
      add_word(MODE_LIGHTEN, 32'h40010000, 32'hFFFFFFFF, 24'h7FFFFF);
      add_word(MODE_LIGHTEN, 32'hFFFFFFFF, 32'h00000000, 24'hFFFFFF);
      add_word(MODE_LIGHTEN, 32'h12345678, 32'h00000000, 24'h000000);
      add_word(MODE_LIGHTEN, 32'hFF010101, 32'h00000000, 24'h008000);
      // blend: full weight, clamp, negative, transparent over color, half weight
      add_word(MODE_BLEND, 32'h80000000, 32'hFFFFFFFF, 24'h010000);
      add_word(MODE_BLEND, 32'h11FFFFFF, 32'hFF000000, 24'h7FFFFF);
      add_word(MODE_BLEND, 32'hAB123456, 32'hFFFFFFFF, 24'h800000);
      add_word(MODE_BLEND, 32'hAB123456, 32'h00FFFFFF, 24'h010000);
      add_word(MODE_BLEND, 32'h00000000, 32'h80FF01FE, 24'h008000);
      add_word(MODE_BLEND, 32'hFFFF00FF, 32'hFF00FF00, 24'hFFFFFF);
      drain();

      for (p = 0; p < NUM_PHASES; p++) begin
         sender_quiet   = (p == 1 || p == 2 || p == 3);
         receiver_quiet = (p == 1 || p == 4);
         // long receiver hold while the sender keeps offering words
         if (p == 2)
            hold_request = 1'b1;
         for (k = 0; k < PHASE_WORDS; k++)
            pending_words.push_back(random_word());
         drain();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
